// File: sv/bitmap_font_text_rasterizer_unit_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the bitmap font text rasteriser
// Shared concurrent assertion forms, clocked on clock, synchronous reset.
// -----------------------------------------------------------------------------
`ifndef BITMAP_FONT_TEXT_RASTERIZER_UNIT_ASSERT_SVH
`define BITMAP_FONT_TEXT_RASTERIZER_UNIT_ASSERT_SVH

// Check that is switched off while reset is high
`define BFTR_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that also runs through reset
`define BFTR_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/bftr_pkg.sv
// -----------------------------------------------------------------------------
// bftr_pkg
// Types, constants and the 5x7 glyph ROM of the bitmap font text rasteriser.
// -----------------------------------------------------------------------------
package bftr_pkg;

   localparam int GLYPH_ROWS = 7;
   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;
   localparam int MAX_TEXT   = 255;
   localparam int IDX_MAX    = 511;
   localparam int DIV_STEPS  = 12;

   localparam logic [7:0] CHAR_MARKER = 8'h3E;   // '>'

   typedef enum logic [2:0] {
      REG_ORIGIN_X    = 3'd0,
      REG_ORIGIN_Y    = 3'd1,
      REG_PIXEL_SCALE = 3'd2,
      REG_FIT_ENABLE  = 3'd3,
      REG_MAX_WIDTH   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       first_of_text;
      logic [8:0] text_length;
   } req_type;

   typedef struct packed {
      logic [14:0] rect_x;
      logic [12:0] rect_y;
      logic [3:0]  rect_size;
      logic        last_of_char;
   } rsp_type;

   typedef struct packed {
      logic       busy;
      logic [7:0] fit_limit;
   } fit_status_type;

   localparam logic [GLYPH_BITS-1:0] QMARK_GLYPH =
      {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};

   // Glyph bits, top row first, leftmost column in the MSB of each row
   function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
      logic [7:0]            c;
      logic [GLYPH_BITS-1:0] g;
      c = code;
      if (code >= 8'h61 && code <= 8'h7A) begin
         c = code - 8'd32;
      end
      unique case (c)
         8'h20: g = '0;
         8'h30: g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
         8'h31: g = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
         8'h32: g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
         8'h33: g = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
         8'h34: g = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
         8'h35: g = {5'd31, 5'd16, 5'd30, 5'd1,  5'd1,  5'd17, 5'd14};
         8'h36: g = {5'd6,  5'd8,  5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
         8'h37: g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
         8'h38: g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
         8'h39: g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd2,  5'd12};
         8'h41: g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
         8'h42: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
         8'h43: g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
         8'h44: g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
         8'h45: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
         8'h46: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
         8'h47: g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
         8'h48: g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
         8'h49: g = {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
         8'h4A: g = {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
         8'h4B: g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
         8'h4C: g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
         8'h4D: g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
         8'h4E: g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
         8'h4F: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
         8'h50: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
         8'h51: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
         8'h52: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
         8'h53: g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
         8'h54: g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
         8'h55: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
         8'h56: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
         8'h57: g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
         8'h58: g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
         8'h59: g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
         8'h5A: g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
         8'h2E: g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
         8'h2F: g = {5'd1,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd16};
         8'h2D: g = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
         8'h5F: g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd31};
         8'h3A: g = {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};
         8'h28: g = {5'd2,  5'd4,  5'd8,  5'd8,  5'd8,  5'd4,  5'd2};
         8'h29: g = {5'd8,  5'd4,  5'd2,  5'd2,  5'd2,  5'd4,  5'd8};
         8'h3C: g = {5'd2,  5'd4,  5'd8,  5'd16, 5'd8,  5'd4,  5'd2};
         8'h3E: g = {5'd8,  5'd4,  5'd2,  5'd1,  5'd2,  5'd4,  5'd8};
         8'h3D: g = {5'd0,  5'd0,  5'd31, 5'd0,  5'd31, 5'd0,  5'd0};
         default: g = QMARK_GLYPH;
      endcase
      return g;
   endfunction

endpackage

// File: sv/bitmap_font_text_rasterizer_unit.sv
// -----------------------------------------------------------------------------
// bitmap_font_text_rasterizer_unit
// 5x7 character generator: one character in, one filled square out per set
// font pixel.
// -----------------------------------------------------------------------------
// Usage:
//  req_*  : one character per transfer; first_of_text restarts pen and index
//           and loads text_length.
//  rsp_*  : one square per transfer; last_of_char marks a character's final
//           square. Blank and clipped characters give no transfer.
//  csr_*  : register writes, taken every cycle (csr_ready is tied high).
// Timing:
//  A drawn character is accepted and reads the registered glyph ROM, then one
//  font-pixel position is scanned per cycle while rsp is not stalled, up to
//  its last set pixel. A character that is not drawn is accepted without a
//  scan. A square is registered into the output by the edge that scans its
//  position; the top-left position is scanned once the glyph is loaded and
//  rsp is not stalled.
//  Each csr write restarts the 12-step fit-limit divider; req_stall is high
//  while the start is registered and the divider runs.
// Reset clears the text state (pen 0, index 0, length 0) and the registers
// to their defaults. A stalled rsp holds its square and freezes the scan;
// req_stall stays high until the character has been fully scanned.
// -----------------------------------------------------------------------------
`include "bitmap_font_text_rasterizer_unit_assert.svh"

module bitmap_font_text_rasterizer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bftr_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bftr_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [11:0]        csr_data
);
   import bftr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [GLYPH_BITS-1:0] glyph_ff, glyph_in;
   logic [2:0]            col_ff,   col_in;
   logic [5:0]            xoff_ff,  xoff_in;
   logic [6:0]            yoff_ff,  yoff_in;
   logic [14:0]           pen_ff,   pen_in;
   logic [8:0]            idx_ff,   idx_in;
   logic [8:0]            held_ff,  held_in;
   rsp_type               rsp_ff,   rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [11:0]           origin_x_ff;
   logic [11:0]           origin_y_ff;
   logic [3:0]            scale_ff;
   logic                  fit_ff;
   logic [11:0]           avail_width_ff;
   logic                  div_start_ff;

   fit_status_type        fit_status;

   logic                  accept;
   logic                  csr_write;
   logic                  step_ok;
   logic                  rest_zero;
   logic [8:0]            idx_base;
   logic [8:0]            held_sel;
   logic [14:0]           pen_base;
   logic                  too_long;
   logic                  draw;
   logic                  marker;
   logic [7:0]            code_sel;
   logic [15:0]           x_sum;
   logic [6:0]            advance;
   logic [15:0]           pen_sum;

   bftr_fitdiv u_fitdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (avail_width_ff),
      .scale    (scale_ff),
      .status   (fit_status)
   );

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = (state_ff != ST_IDLE) || fit_status.busy || div_start_ff;
   assign accept    = req_valid && !req_stall;
   assign step_ok   = !rsp_valid_ff || !rsp_stall;
   assign rest_zero = (glyph_ff[GLYPH_BITS-2:0] == '0);

   // per-character decisions taken at the accepting edge
   assign idx_base = req_data.first_of_text ? 9'd0 : idx_ff;
   assign held_sel = req_data.first_of_text ? req_data.text_length : held_ff;
   assign pen_base = req_data.first_of_text ? {3'b000, origin_x_ff} : pen_ff;
   assign too_long = held_sel > {1'b0, fit_status.fit_limit};
   assign draw     = (scale_ff != 4'd0) &&
                     (!fit_ff || ((fit_status.fit_limit != 8'd0) &&
                      !(too_long && (idx_base >= {1'b0, fit_status.fit_limit}))));
   assign marker   = fit_ff && too_long &&
                     (({1'b0, idx_base} + 10'd1) == {2'b00, fit_status.fit_limit});
   assign code_sel = marker ? CHAR_MARKER : req_data.char_code;

   assign x_sum    = {1'b0, pen_ff} + {10'd0, xoff_ff};
   assign advance  = {1'b0, scale_ff, 2'b00} + {2'b00, scale_ff, 1'b0};
   assign pen_sum  = {1'b0, pen_ff} + {9'd0, advance};

   always_comb begin
      state_in     = state_ff;
      glyph_in     = glyph_ff;
      col_in       = col_ff;
      xoff_in      = xoff_ff;
      yoff_in      = yoff_ff;
      pen_in       = pen_ff;
      idx_in       = idx_ff;
      held_in      = held_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pen_in  = pen_base;
               held_in = held_sel;
               idx_in  = (idx_base != 9'(IDX_MAX)) ? idx_base + 9'd1 : idx_base;
               if (draw) begin
                  glyph_in = glyph_bits(code_sel);
                  col_in   = '0;
                  xoff_in  = '0;
                  yoff_in  = '0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (step_ok) begin
               if (glyph_ff[GLYPH_BITS-1]) begin
                  rsp_in.rect_x       = x_sum[15] ? 15'h7FFF : x_sum[14:0];
                  rsp_in.rect_y       = {1'b0, origin_y_ff} + {6'd0, yoff_ff};
                  rsp_in.rect_size    = scale_ff;
                  rsp_in.last_of_char = rest_zero;
                  rsp_valid_in        = 1'b1;
               end
               glyph_in = {glyph_ff[GLYPH_BITS-2:0], 1'b0};
               if (col_ff == 3'(GLYPH_COLS - 1)) begin
                  col_in  = '0;
                  xoff_in = '0;
                  yoff_in = yoff_ff + {3'b000, scale_ff};
               end else begin
                  col_in  = col_ff + 3'd1;
                  xoff_in = xoff_ff + {2'b00, scale_ff};
               end
               // no set pixel left: advance the pen and drop out
               if (rest_zero) begin
                  pen_in   = pen_sum[15] ? 15'h7FFF : pen_sum[14:0];
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_ff       <= '0;
         idx_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_ff       <= pen_in;
         idx_ff       <= idx_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      glyph_ff <= glyph_in;
      col_ff   <= col_in;
      xoff_ff  <= xoff_in;
      yoff_ff  <= yoff_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         scale_ff       <= 4'd1;
         fit_ff         <= 1'b0;
         avail_width_ff <= '0;
         div_start_ff   <= 1'b0;
      end else begin
         div_start_ff <= csr_write;
         if (csr_write) begin
            unique case (csr_index)
               REG_ORIGIN_X:    origin_x_ff    <= csr_data;
               REG_ORIGIN_Y:    origin_y_ff    <= csr_data;
               REG_PIXEL_SCALE: scale_ff       <= csr_data[3:0];
               REG_FIT_ENABLE:  fit_ff         <= csr_data[0];
               REG_MAX_WIDTH:   avail_width_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BFTR_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid), "not idle after reset")
   `BFTR_ASSERT(a_size_nonzero, rsp_valid |-> (rsp_data.rect_size != 4'd0), "square of zero size")
   `BFTR_ASSERT(a_col_range, (state_ff == ST_EMIT) |-> (col_ff <= 3'(GLYPH_COLS - 1)), "column out of range")
   `BFTR_ASSERT(a_scan_drained, (state_ff == ST_EMIT && state_in == ST_IDLE) |=> (glyph_ff == '0), "scan ended early")
   `BFTR_ASSERT(a_pen_held, (state_ff == ST_EMIT && state_in == ST_EMIT) |=> $stable(pen_ff), "pen moved mid character")

endmodule

// File: sv/bftr_fitdiv.sv
// -----------------------------------------------------------------------------
// bftr_fitdiv
// Restoring divider for the fit limit: available width / (6*scale), capped at
// MAX_TEXT, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module bftr_fitdiv (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [11:0]                  dividend,
   input  logic [3:0]                   scale,
   output bftr_pkg::fit_status_type     status
);
   import bftr_pkg::*;

   logic              busy_ff,  busy_in;
   logic [3:0]        cnt_ff,   cnt_in;
   logic [6:0]        div_ff,   div_in;
   logic [6:0]        rem_ff,   rem_in;
   logic [11:0]       work_ff,  work_in;
   logic [7:0]        maxc_ff,  maxc_in;
   logic [7:0]        trial;

   assign trial = {rem_ff, work_ff[11]};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      work_in = work_ff;
      maxc_in = maxc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = {1'b0, scale, 2'b00} + {2'b00, scale, 1'b0};
         rem_in  = '0;
         work_in = dividend;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in  = 7'(trial - {1'b0, div_ff});
            work_in = {work_ff[10:0], 1'b1};
         end else begin
            rem_in  = trial[6:0];
            work_in = {work_ff[10:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            maxc_in = (work_in > 12'(MAX_TEXT)) ? 8'(MAX_TEXT) : work_in[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         maxc_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         maxc_ff <= maxc_in;
      end
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      work_ff <= work_in;
   end

   assign status.busy      = busy_ff;
   assign status.fit_limit = maxc_ff;

endmodule

// File: test/bitmap_font_text_rasterizer_checker.sv
// -----------------------------------------------------------------------------
// bitmap_font_text_rasterizer_checker
// Watches the register, character and square channels of the 5x7 text
// rasteriser. Keeps its own copy of the registers, pen and text index. Works
// out the squares each accepted character must produce, and compares every
// square transfer field by field against the oldest square still owed.
// -----------------------------------------------------------------------------
module bitmap_font_text_rasterizer_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  bftr_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  bftr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [11:0]       csr_data,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import bftr_pkg::*;

   localparam int PEN_LIMIT    = 32767;
   localparam int INDEX_LIMIT  = 511;
   localparam int ADVANCE      = 6;
   localparam int REPORT_LIMIT = 40;
   localparam logic [7:0] CLIP_MARK = ">";

   logic [34:0] font_rom [0:255];

   logic [11:0] origin_x;
   logic [11:0] origin_y;
   logic [3:0]  pixel_scale;
   logic        fit_enable;
   logic [11:0] avail_width;

   int          pen_x;
   int          char_slot;
   logic [8:0]  held_length;

   rsp_type     expected_squares [$];
   int          errors = 0;

   function automatic logic [34:0] glyph_rows(input int r0, r1, r2, r3, r4, r5, r6);
      return {r0[4:0], r1[4:0], r2[4:0], r3[4:0], r4[4:0], r5[4:0], r6[4:0]};
   endfunction

   initial begin
      for (int c = 0; c < 256; c++) font_rom[c] = '0;
      font_rom["0"] = glyph_rows(14, 17, 19, 21, 25, 17, 14);
      font_rom["1"] = glyph_rows(4, 12, 4, 4, 4, 4, 14);
      font_rom["2"] = glyph_rows(14, 17, 1, 2, 4, 8, 31);
      font_rom["3"] = glyph_rows(30, 1, 1, 14, 1, 1, 30);
      font_rom["4"] = glyph_rows(2, 6, 10, 18, 31, 2, 2);
      font_rom["5"] = glyph_rows(31, 16, 30, 1, 1, 17, 14);
      font_rom["6"] = glyph_rows(6, 8, 16, 30, 17, 17, 14);
      font_rom["7"] = glyph_rows(31, 1, 2, 4, 8, 8, 8);
      font_rom["8"] = glyph_rows(14, 17, 17, 14, 17, 17, 14);
      font_rom["9"] = glyph_rows(14, 17, 17, 15, 1, 2, 12);
      font_rom["A"] = glyph_rows(14, 17, 17, 31, 17, 17, 17);
      font_rom["B"] = glyph_rows(30, 17, 17, 30, 17, 17, 30);
      font_rom["C"] = glyph_rows(14, 17, 16, 16, 16, 17, 14);
      font_rom["D"] = glyph_rows(30, 17, 17, 17, 17, 17, 30);
      font_rom["E"] = glyph_rows(31, 16, 16, 30, 16, 16, 31);
      font_rom["F"] = glyph_rows(31, 16, 16, 30, 16, 16, 16);
      font_rom["G"] = glyph_rows(14, 17, 16, 23, 17, 17, 15);
      font_rom["H"] = glyph_rows(17, 17, 17, 31, 17, 17, 17);
      font_rom["I"] = glyph_rows(14, 4, 4, 4, 4, 4, 14);
      font_rom["J"] = glyph_rows(7, 2, 2, 2, 18, 18, 12);
      font_rom["K"] = glyph_rows(17, 18, 20, 24, 20, 18, 17);
      font_rom["L"] = glyph_rows(16, 16, 16, 16, 16, 16, 31);
      font_rom["M"] = glyph_rows(17, 27, 21, 21, 17, 17, 17);
      font_rom["N"] = glyph_rows(17, 25, 21, 19, 17, 17, 17);
      font_rom["O"] = glyph_rows(14, 17, 17, 17, 17, 17, 14);
      font_rom["P"] = glyph_rows(30, 17, 17, 30, 16, 16, 16);
      font_rom["Q"] = glyph_rows(14, 17, 17, 17, 21, 18, 13);
      font_rom["R"] = glyph_rows(30, 17, 17, 30, 20, 18, 17);
      font_rom["S"] = glyph_rows(15, 16, 16, 14, 1, 1, 30);
      font_rom["T"] = glyph_rows(31, 4, 4, 4, 4, 4, 4);
      font_rom["U"] = glyph_rows(17, 17, 17, 17, 17, 17, 14);
      font_rom["V"] = glyph_rows(17, 17, 17, 17, 17, 10, 4);
      font_rom["W"] = glyph_rows(17, 17, 17, 21, 21, 21, 10);
      font_rom["X"] = glyph_rows(17, 17, 10, 4, 10, 17, 17);
      font_rom["Y"] = glyph_rows(17, 17, 10, 4, 4, 4, 4);
      font_rom["Z"] = glyph_rows(31, 1, 2, 4, 8, 16, 31);
      font_rom["?"] = glyph_rows(14, 17, 1, 2, 4, 0, 4);
      font_rom["."] = glyph_rows(0, 0, 0, 0, 0, 12, 12);
      font_rom["/"] = glyph_rows(1, 1, 2, 4, 8, 16, 16);
      font_rom["-"] = glyph_rows(0, 0, 0, 31, 0, 0, 0);
      font_rom["_"] = glyph_rows(0, 0, 0, 0, 0, 0, 31);
      font_rom[":"] = glyph_rows(0, 12, 12, 0, 12, 12, 0);
      font_rom["("] = glyph_rows(2, 4, 8, 8, 8, 4, 2);
      font_rom[")"] = glyph_rows(8, 4, 2, 2, 2, 4, 8);
      font_rom["<"] = glyph_rows(2, 4, 8, 16, 8, 4, 2);
      font_rom[">"] = glyph_rows(8, 4, 2, 1, 2, 4, 8);
      font_rom["="] = glyph_rows(0, 0, 31, 0, 31, 0, 0);
   end

   // Fold lowercase, keep space blank, send every other unknown code to '?'
   function automatic logic [34:0] glyph_for(input logic [7:0] code);
      logic [7:0] c;
      c = (code >= "a" && code <= "z") ? code - 8'd32 : code;
      if (c == " ") return '0;
      if (font_rom[c] == '0) return font_rom["?"];
      return font_rom[c];
   endfunction

   task automatic rasterise_char(input req_type item);
      logic [7:0]  code;
      logic [34:0] bits;
      logic        draw;
      int          slot, limit, total, seen, x;
      rsp_type     sq;
      code = item.char_code;
      if (item.first_of_text) begin
         pen_x       = origin_x;
         char_slot   = 0;
         held_length = item.text_length;
      end
      slot = char_slot;
      if (char_slot < INDEX_LIMIT) char_slot++;

      draw = (pixel_scale != 0);
      if (draw && fit_enable) begin
         limit = avail_width / (ADVANCE * pixel_scale);
         if (limit > MAX_TEXT) limit = MAX_TEXT;
         if (limit == 0) begin
            draw = 1'b0;
         end else if (held_length > limit) begin
            if (slot + 1 == limit) code = CLIP_MARK;
            else if (slot >= limit) draw = 1'b0;
         end
      end
      if (!draw) return;

      bits  = glyph_for(code);
      total = $countones(bits);
      seen  = 0;
      for (int row = 0; row < 7; row++) begin
         for (int col = 0; col < 5; col++) begin
            if (bits[34 - (row * 5 + col)]) begin
               seen++;
               x = pen_x + col * pixel_scale;
               if (x > PEN_LIMIT) x = PEN_LIMIT;
               sq.rect_x       = x[14:0];
               sq.rect_y       = 13'(origin_y + row * pixel_scale);
               sq.rect_size    = pixel_scale;
               sq.last_of_char = (seen == total);
               expected_squares.push_back(sq);
            end
         end
      end
      pen_x = pen_x + ADVANCE * pixel_scale;
      if (pen_x > PEN_LIMIT) pen_x = PEN_LIMIT;
   endtask

   task automatic report_field(input string field, input int want, input int got);
      errors++;
      if (errors <= REPORT_LIMIT)
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
   endtask

   task automatic check_square(input rsp_type got);
      rsp_type want;
      if (expected_squares.size() == 0) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t ns: square expected none, got x=%0d y=%0d size=%0d last=%0b",
                     $time, got.rect_x, got.rect_y, got.rect_size, got.last_of_char);
         return;
      end
      want = expected_squares.pop_front();
      if (got.rect_x !== want.rect_x) report_field("rect_x", want.rect_x, got.rect_x);
      if (got.rect_y !== want.rect_y) report_field("rect_y", want.rect_y, got.rect_y);
      if (got.rect_size !== want.rect_size)
         report_field("rect_size", want.rect_size, got.rect_size);
      if (got.last_of_char !== want.last_of_char)
         report_field("last_of_char", want.last_of_char, got.last_of_char);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         origin_x    = '0;
         origin_y    = '0;
         pixel_scale = 4'd1;
         fit_enable  = 1'b0;
         avail_width = '0;
         pen_x       = 0;
         char_slot   = 0;
         held_length = '0;
         expected_squares.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ORIGIN_X:    origin_x    = csr_data;
               REG_ORIGIN_Y:    origin_y    = csr_data;
               REG_PIXEL_SCALE: pixel_scale = csr_data[3:0];
               REG_FIT_ENABLE:  fit_enable  = csr_data[0];
               REG_MAX_WIDTH:   avail_width = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) rasterise_char(req_data);
         if (rsp_valid && !rsp_stall) check_square(rsp_data);
      end
      fail_count <= errors;
      pending    <= expected_squares.size();
   end

endmodule

// File: test/tb_bitmap_font_text_rasterizer_unit.sv
// -----------------------------------------------------------------------------
// tb_bitmap_font_text_rasterizer_unit
// Drives characters and register writes into the text rasteriser, stalls
// the square channel on shifting patterns and leaves prediction and
// comparison to the checker. Directed characters cover case folding, blank
// and unknown codes, zero scale and fit clipping; a long text pushes the
// pen into saturation; random phases follow with fixed, then random registers.
// -----------------------------------------------------------------------------
module tb_bitmap_font_text_rasterizer_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import bftr_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 48;
   localparam int RANDOM_ITEMS   = 48;
   localparam int PHASES         = 6;
   localparam int CLIP_ITEMS     = 20;
   localparam int SAT_ITEMS      = 325;

   typedef enum int {FLOW, LIGHT, HEAVY, BEAT} stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [11:0] csr_data;
   int          fail_count;
   int          pending;
   logic        any_transfer;

   int             burst_left = 0;
   stall_mode_type stall_mode = FLOW;
   int             stall_left = 0;
   logic [3:0]     beat = '0;

   bitmap_font_text_rasterizer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   bitmap_font_text_rasterizer_checker square_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   assign any_transfer = (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                         (csr_valid && csr_ready);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Square receiver: switch between free flow, light, heavy and beat stalls
   always @(posedge clock) begin
      beat <= beat + 1'b1;
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(30, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         FLOW:    rsp_stall <= 1'b0;
         LIGHT:   rsp_stall <= ($urandom_range(0, 3) == 0);
         HEAVY:   rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= beat[3];
      endcase
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (any_transfer) quiet = 0;
         else quiet++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic [7:0] pick_char();
      string marks;
      int    roll;
      marks = "./-_:()<>=?#@";
      roll  = $urandom_range(0, 99);
      if (roll < 30) return 8'($urandom_range("A", "Z"));
      if (roll < 50) return 8'($urandom_range("a", "z"));
      if (roll < 60) return 8'($urandom_range("0", "9"));
      if (roll < 75) return marks[$urandom_range(0, marks.len() - 1)];
      if (roll < 85) return " ";
      return 8'($urandom_range(0, 255));
   endfunction

   // Sender works in bursts; hold the payload while stalled
   task automatic send_char(input logic [7:0] code, input logic starts_text,
                            input logic [8:0] length_field);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= req_type'{char_code: code, first_of_text: starts_text,
                             text_length: length_field};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_text(input int count, input logic [8:0] length_field,
                            input int blank_pct);
      logic [7:0] c;
      for (int k = 0; k < count; k++) begin
         c = ($urandom_range(0, 99) < blank_pct) ? 8'h20 : pick_char();
         send_char(c, k == 0, length_field);
      end
   endtask

   task automatic csr_write(input csr_index_type which, input logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_regs(input logic [11:0] ox, input logic [11:0] oy,
                               input logic [3:0] scale, input logic fit,
                               input logic [11:0] width);
      csr_write(REG_ORIGIN_X, ox);
      csr_write(REG_ORIGIN_Y, oy);
      csr_write(REG_PIXEL_SCALE, {8'd0, scale});
      csr_write(REG_FIT_ENABLE, {11'd0, fit});
      csr_write(REG_MAX_WIDTH, width);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every owed square, then let undrawn characters finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [11:0] ox, oy, width;
      logic [3:0]  scale;
      logic        fit;
      int          sent, len;
      logic [8:0]  length_field;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // no text started yet: pen at zero, length zero
      send_char("A", 1'b0, 9'd0);
      send_char("z", 1'b0, 9'd0);
      send_char(8'h00, 1'b0, 9'h1FF);
      send_char(8'hFF, 1'b0, 9'd0);
      send_char(" ", 1'b0, 9'd0);
      send_char(8'h7F, 1'b0, 9'd0);
      send_char(8'h1F, 1'b0, 9'd0);
      send_char("~", 1'b0, 9'd0);
      send_char("8", 1'b1, 9'h1FF);
      send_char("#", 1'b0, 9'd0);
      send_char("@", 1'b0, 9'd0);
      settle();

      // zero scale draws nothing and leaves the pen where it is
      program_regs(12'd0, 12'd0, 4'd0, 1'b0, 12'd0);
      send_char("W", 1'b1, 9'd5);
      send_char("M", 1'b0, 9'd0);
      settle();

      // three characters fit: third becomes the marker, the rest drop
      program_regs(12'd4095, 12'd4095, 4'd15, 1'b1, 12'd270);
      send_char("A", 1'b1, 9'd5);
      send_char("B", 1'b0, 9'd5);
      send_char("C", 1'b0, 9'd5);
      send_char("D", 1'b0, 9'd5);
      send_char("E", 1'b0, 9'd5);
      settle();

      // width below one advance: nothing fits
      program_regs(12'd4095, 12'd4095, 4'd15, 1'b1, 12'd89);
      send_char("H", 1'b1, 9'd1);
      settle();

      // two characters fit in a long text: second is the marker
      program_regs(12'd0, 12'd0, 4'd1, 1'b1, 12'd12);
      send_text(CLIP_ITEMS, 9'd300, 50);
      settle();

      // pen runs into saturation
      program_regs(12'd4095, 12'd0, 4'd15, 1'b0, 12'd0);
      send_text(SAT_ITEMS, 9'd340, 90);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            ox = 12'd0; oy = 12'd0; scale = 4'd1; fit = 1'b0; width = 12'd0;
         end else if (phase == 1) begin
            ox = 12'd4095; oy = 12'd4095; scale = 4'd15; fit = 1'b1; width = 12'd4095;
         end else begin
            ox = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 12'd4095 : 12'd0)
                                             : 12'($urandom_range(0, 4095));
            oy = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 12'd4095 : 12'd0)
                                             : 12'($urandom_range(0, 4095));
            scale = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
            fit   = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0)
               width = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            else if (fit)
               width = 12'($urandom_range(0, 10) * 6 * scale + $urandom_range(0, 6 * scale));
            else
               width = 12'($urandom_range(0, 4095));
         end
         program_regs(ox, oy, scale, fit, width);

         sent = 0;
         while (sent < RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 9) == 0) begin
               // stray character with random flags
               send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         9'($urandom_range(0, 511)));
               sent++;
            end else begin
               len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
               length_field = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                                          : 9'(len);
               send_text(len, length_field, 10);
               sent += len;
            end
         end
         settle();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
